@@ design/min_heap_priority_queue_assert.svh @@
// Assertion macros for the min-heap priority queue checker
`ifndef MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// consequent checked in the same cycle
`define MHPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mhpq_pkg.sv @@
// Shared types, codes and constants of the min-heap priority queue
package mhpq_pkg;

  localparam int KEY_W        = 32;
  localparam int COUNT_W      = 10;
  localparam int STATUS_W     = 2;
  localparam int DEF_CAPACITY = 1023;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam key_t NO_KEY = -32'sd1;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_RM_LAST,
    ST_RM_LOAD,
    ST_DN_RD,
    ST_DN_L,
    ST_DN_R,
    ST_DONE
  } state_t;

endpackage

@@ design/mhpq_in_if.sv @@
// Request channel: operation and key
interface mhpq_in_if import mhpq_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       func;
  key_t       key_in;

  modport source (output valid, output func, output key_in, input ready);
  modport sink   (input valid, input func, input key_in, output ready);
endinterface

@@ design/mhpq_out_if.sv @@
// Result channel: removed key, status and entry count
interface mhpq_out_if import mhpq_pkg::*; ();
  logic                valid;
  logic                ready;
  key_t                removed_key;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output removed_key, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input removed_key, input status, input entry_count,
                  output ready);
endinterface

@@ design/mhpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module mhpq_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/min_heap_priority_queue.sv @@
// Binary min-heap priority queue: sequencer, shared comparator and key RAM
// A full insert or an empty remove goes straight to the result. Each level costs one RAM read
// per key looked at. A new request is taken only in idle, once the last one has finished;
// a finished result waits in an output register while the next beat is taken.
// Reset (synchronous, rst_n low) empties the heap; the key RAM is not cleared.
module min_heap_priority_queue import mhpq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  mhpq_in_if.sink    in_if,
  mhpq_out_if.source out_if
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  key_t                 key_r, key_nxt;
  key_t                 best_key_r, best_key_nxt;
  logic                 best_child_r, best_child_nxt;
  key_t                 removed_r, removed_nxt;
  status_t              status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  key_t                 out_key_r, out_key_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;

  logic                 in_take;
  logic                 full;
  logic [CNT_W:0]       child_l, child_r, cnt_ext;
  logic [CNT_W-1:0]     parent;
  key_t                 cmp_a, cmp_b;
  logic                 cmp_lt;

  logic                 wr_en;
  logic [CNT_W-1:0]     wr_addr, rd_addr;
  key_t                 wr_data;
  logic [KEY_W-1:0]     rd_raw;
  key_t                 rd_data;

  mhpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY + 1)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_data = rd_raw;

  assign in_take = in_if.valid && in_if.ready;
  assign full    = (cnt_r == CNT_W'(CAPACITY));
  assign child_l = {pos_r, 1'b0};
  assign child_r = {pos_r, 1'b1};
  assign cnt_ext = {1'b0, cnt_r};
  assign parent  = pos_r >> 1;

  // shared signed comparator
  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          unique case (in_if.func)
            FUNC_INSERT: state_nxt = full ? ST_DONE : ST_UP_RD;
            FUNC_REMOVE: state_nxt = (cnt_r == '0) ? ST_DONE : ST_RM_LAST;
          endcase
        end
      end
      ST_UP_RD:   state_nxt = (pos_r == CNT_W'(1)) ? ST_DONE : ST_UP_CMP;
      ST_UP_CMP:  state_nxt = cmp_lt ? ST_UP_RD : ST_DONE;
      ST_RM_LAST: state_nxt = ST_RM_LOAD;
      ST_RM_LOAD: state_nxt = (cnt_r == CNT_W'(1)) ? ST_DONE : ST_DN_RD;
      ST_DN_RD:   state_nxt = (child_l > cnt_ext) ? ST_DONE : ST_DN_L;
      ST_DN_L: begin
        if (child_r <= cnt_ext) begin
          state_nxt = ST_DN_R;
        end else begin
          state_nxt = cmp_lt ? ST_DN_RD : ST_DONE;
        end
      end
      ST_DN_R:    state_nxt = (cmp_lt || best_child_r) ? ST_DN_RD : ST_DONE;
      ST_DONE:    state_nxt = (!out_valid_r || out_if.ready) ? ST_IDLE : ST_DONE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    best_key_nxt   = best_key_r;
    best_child_nxt = best_child_r;
    removed_nxt    = removed_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_key_nxt    = out_key_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_data        = key_r;
    rd_addr        = CNT_W'(1);
    cmp_a          = key_r;
    cmp_b          = rd_data;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          key_nxt     = in_if.key_in;
          removed_nxt = NO_KEY;
          status_nxt  = STATUS_OK;
          unique case (in_if.func)
            FUNC_INSERT: begin
              if (full) begin
                status_nxt = STATUS_FULL;
              end else begin
                cnt_nxt = cnt_r + CNT_W'(1);
                pos_nxt = cnt_r + CNT_W'(1);
              end
            end
            FUNC_REMOVE: begin
              if (cnt_r == '0) begin
                status_nxt = STATUS_EMPTY;
              end
            end
          endcase
        end
      end
      ST_UP_RD: begin
        if (pos_r == CNT_W'(1)) begin
          wr_en = 1'b1;
        end else begin
          rd_addr = parent;
        end
      end
      ST_UP_CMP: begin
        wr_en = 1'b1;
        if (cmp_lt) begin
          wr_data = rd_data;
          pos_nxt = parent;
        end
      end
      ST_RM_LAST: begin
        removed_nxt = rd_data;
        rd_addr     = cnt_r;
      end
      ST_RM_LOAD: begin
        key_nxt = rd_data;
        cnt_nxt = cnt_r - CNT_W'(1);
        pos_nxt = CNT_W'(1);
      end
      ST_DN_RD: begin
        if (child_l > cnt_ext) begin
          wr_en = 1'b1;
        end else begin
          rd_addr = child_l[CNT_W-1:0];
        end
      end
      ST_DN_L: begin
        cmp_a          = rd_data;
        cmp_b          = key_r;
        best_key_nxt   = cmp_lt ? rd_data : key_r;
        best_child_nxt = cmp_lt;
        if (child_r <= cnt_ext) begin
          rd_addr = child_r[CNT_W-1:0];
        end else begin
          wr_en = 1'b1;
          if (cmp_lt) begin
            wr_data = rd_data;
            pos_nxt = child_l[CNT_W-1:0];
          end
        end
      end
      ST_DN_R: begin
        cmp_a = rd_data;
        cmp_b = best_key_r;
        wr_en = 1'b1;
        if (cmp_lt) begin
          wr_data = rd_data;
          pos_nxt = child_r[CNT_W-1:0];
        end else if (best_child_r) begin
          wr_data = best_key_r;
          pos_nxt = child_l[CNT_W-1:0];
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_key_nxt    = removed_r;
          out_status_nxt = status_r;
          out_count_nxt  = COUNT_W'(cnt_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    best_key_r   <= best_key_nxt;
    best_child_r <= best_child_nxt;
    removed_r    <= removed_nxt;
    status_r     <= status_nxt;
    out_key_r    <= out_key_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_if.ready        = (state_r == ST_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.removed_key = out_key_r;
  assign out_if.status      = out_status_r;
  assign out_if.entry_count = out_count_r;

endmodule

@@ design/min_heap_priority_queue_chk.sv @@
// Port-level checker for the min-heap priority queue, bound to the top level
`include "min_heap_priority_queue_assert.svh"

module min_heap_priority_queue_chk import mhpq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input key_t                out_removed_key,
  input logic [STATUS_W-1:0] out_status,
  input logic [COUNT_W-1:0]  out_entry_count
);

  `MHPQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_removed_key) && $stable(out_status) && $stable(out_entry_count), "result beat changed while stalled")

  `MHPQ_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready, "ready right after a request beat")

  `MHPQ_ASSERT_SAME(a_fail_no_key, clk, rst_n, out_valid && out_status != STATUS_OK, out_removed_key == NO_KEY, "failed operation returned a key")

  `MHPQ_ASSERT_SAME(a_full_count, clk, rst_n, out_valid && out_status == STATUS_FULL, out_entry_count == COUNT_W'(CAPACITY), "full status with wrong count")

  `MHPQ_ASSERT_SAME(a_empty_count, clk, rst_n, out_valid && out_status == STATUS_EMPTY, out_entry_count == '0, "empty status with nonzero count")

endmodule

bind min_heap_priority_queue min_heap_priority_queue_chk #(.CAPACITY(CAPACITY)) u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_removed_key (out_if.removed_key),
  .out_status      (out_if.status),
  .out_entry_count (out_if.entry_count)
);

@@ tb/tb_min_heap_priority_queue.sv @@
// Self-checking testbench for the min-heap priority queue: random-stall driver, monitor, heap model
module tb_min_heap_priority_queue;
  import mhpq_pkg::*;

  localparam int HEAP_CAP = DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 30;
  localparam key_t KEY_MAX = 32'sh7FFF_FFFF;
  localparam key_t KEY_MIN = 32'sh8000_0000;

  typedef struct {
    logic func;
    key_t key;
  } heap_op_t;

  typedef struct {
    key_t               removed_key;
    status_t            status;
    logic [COUNT_W-1:0] entry_count;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n;

  mhpq_in_if  in_if ();
  mhpq_out_if out_if ();

  min_heap_priority_queue #(.CAPACITY(HEAP_CAP)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  heap_op_t     op_queue[$];
  heap_result_t pending_results[$];
  heap_op_t     cur_op;

  key_t        heap_keys [1:HEAP_CAP];
  int unsigned heap_fill = 0;
  int          plan_fill = 0;

  bit in_fire = 1'b0;
  int in_count = 0;
  int cycle_count = 0;
  int err_count = 0;
  int n_checked = 0;
  int n_insert = 0;
  int n_remove = 0;
  int n_empty = 0;
  int n_full = 0;
  int peak_fill = 0;

  // model of the heap, applied once per accepted input beat
  function automatic heap_result_t heap_apply(input logic func, input key_t key);
    heap_result_t r;
    int unsigned  pos;
    int unsigned  best;
    int unsigned  lc;
    key_t         t;
    bit           settled;
    r.removed_key = NO_KEY;
    r.status      = STATUS_OK;
    if (func == FUNC_INSERT) begin
      if (heap_fill >= HEAP_CAP) begin
        r.status = STATUS_FULL;
      end else begin
        heap_fill++;
        heap_keys[heap_fill] = key;
        pos = heap_fill;
        while (pos > 1 && heap_keys[pos] < heap_keys[pos / 2]) begin
          t = heap_keys[pos];
          heap_keys[pos] = heap_keys[pos / 2];
          heap_keys[pos / 2] = t;
          pos = pos / 2;
        end
      end
    end else if (heap_fill == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.removed_key = heap_keys[1];
      heap_keys[1] = heap_keys[heap_fill];
      heap_fill--;
      pos = 1;
      settled = 1'b0;
      while (!settled) begin
        best = pos;
        lc = 2 * pos;
        // left child wins ties: right only replaces on strictly smaller
        if (lc <= heap_fill && heap_keys[lc] < heap_keys[best]) best = lc;
        if (lc + 1 <= heap_fill && heap_keys[lc + 1] < heap_keys[best]) best = lc + 1;
        if (best == pos) begin
          settled = 1'b1;
        end else begin
          t = heap_keys[best];
          heap_keys[best] = heap_keys[pos];
          heap_keys[pos] = t;
          pos = best;
        end
      end
    end
    r.entry_count = COUNT_W'(heap_fill);
    return r;
  endfunction

  function automatic bit take_break();
    if (in_count >= 700 && in_count < 1000) return 1'b0;
    return $urandom_range(0, 99) < 14;
  endfunction

  function automatic key_t pick_key();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return KEY_MAX;
          1: return KEY_MIN;
          2: return 32'sd0;
          3: return NO_KEY;
          default: return 32'sd1;
        endcase
      end
      1, 2: return key_t'($urandom_range(0, 16)) - 32'sd8;
      default: return key_t'($urandom);
    endcase
  endfunction

  task automatic push_op(input logic func, input key_t key);
    heap_op_t op;
    op.func = func;
    op.key  = key;
    op_queue.push_back(op);
    if (func == FUNC_INSERT && plan_fill < HEAP_CAP) plan_fill++;
    if (func == FUNC_REMOVE && plan_fill > 0) plan_fill--;
  endtask

  task automatic push_random(input int insert_pct);
    if ($urandom_range(0, 99) < insert_pct) push_op(FUNC_INSERT, pick_key());
    else push_op(FUNC_REMOVE, key_t'($urandom));
  endtask

  // driver: one beat presented at a time, held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !take_break();
      if (!in_if.valid || in_fire) begin
        in_fire = 1'b0;
        if (op_queue.size() != 0 && !take_break()) begin
          cur_op = op_queue.pop_front();
          in_if.valid  <= 1'b1;
          in_if.func   <= cur_op.func;
          in_if.key_in <= cur_op.key;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    heap_result_t got_exp;
    cycle_count++;
    if (rst_n && in_if.valid && in_if.ready) begin
      pending_results.push_back(heap_apply(in_if.func, in_if.key_in));
      in_fire = 1'b1;
      in_count++;
      if (in_if.func == FUNC_INSERT) n_insert++;
      else n_remove++;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: unexpected result beat key=%0d status=%0d count=%0d", $time,
                   out_if.removed_key, out_if.status, out_if.entry_count);
      end else begin
        got_exp = pending_results.pop_front();
        n_checked++;
        if (out_if.removed_key !== got_exp.removed_key) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: removed_key expected %0d actual %0d", $time,
                     got_exp.removed_key, out_if.removed_key);
        end
        if (out_if.status !== got_exp.status) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: status expected %0d actual %0d", $time,
                     got_exp.status, out_if.status);
        end
        if (out_if.entry_count !== got_exp.entry_count) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     got_exp.entry_count, out_if.entry_count);
        end
        if (got_exp.status == STATUS_EMPTY) n_empty++;
        if (got_exp.status == STATUS_FULL) n_full++;
        if (int'(got_exp.entry_count) > peak_fill) peak_fill = int'(got_exp.entry_count);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(negedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
    $display("FAIL min_heap_priority_queue");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.func   = FUNC_INSERT;
    in_if.key_in = '0;
    out_if.ready = 1'b0;

    // directed: empty remove, extremes, ties, full drain, sift to root
    push_op(FUNC_REMOVE, NO_KEY);
    push_op(FUNC_INSERT, KEY_MAX);
    push_op(FUNC_INSERT, KEY_MIN);
    push_op(FUNC_INSERT, 32'sd0);
    push_op(FUNC_INSERT, NO_KEY);
    push_op(FUNC_INSERT, 32'sd5);
    push_op(FUNC_INSERT, 32'sd5);
    push_op(FUNC_INSERT, 32'sd5);
    push_op(FUNC_INSERT, 32'sd3);
    push_op(FUNC_INSERT, KEY_MIN);
    push_op(FUNC_INSERT, -32'sd100);
    repeat (11) push_op(FUNC_REMOVE, key_t'($urandom));
    push_op(FUNC_INSERT, 32'sd9);
    push_op(FUNC_INSERT, 32'sd8);
    push_op(FUNC_INSERT, 32'sd7);

    // random: shallow walk, fill to full, drops at full, heavy drain
    repeat (300) push_random(50);
    while (plan_fill < HEAP_CAP) push_random(97);
    repeat (30) push_random(80);
    repeat (330) push_random(15);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || in_if.valid) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    $display("checked %0d results: %0d inserts (%0d dropped when full), %0d removes (%0d on empty)",
             n_checked, n_insert, n_full, n_remove, n_empty);
    $display("heap depth reached %0d of %0d keys", peak_fill, HEAP_CAP);
    if (err_count == 0) begin
      $display("PASS min_heap_priority_queue");
    end else begin
      $display("FAIL min_heap_priority_queue");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/mhpq_pkg.sv
design/mhpq_in_if.sv
design/mhpq_out_if.sv
design/mhpq_ram.sv
design/min_heap_priority_queue.sv
design/min_heap_priority_queue_chk.sv
tb/tb_min_heap_priority_queue.sv
